// ----- hdl/line_segment_point_sampler_unit_assert.svh -----
// Assertion macros for the line segment point sampler
`ifndef LINE_SEGMENT_POINT_SAMPLER_UNIT_ASSERT_SVH
`define LINE_SEGMENT_POINT_SAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LSPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LSPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lsps_pkg.sv -----
// Shared types and constants of the line segment point sampler
`default_nettype none

package lsps_pkg;

    localparam int COORD_W   = 32;
    localparam int RES_W     = 31;
    localparam int IDX_W     = 6;
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int D2_W      = PROD_W + 1;
    localparam int SQ_W      = 2 * (RES_W + IDX_W);
    localparam int REM_W     = IDX_W + 1;
    localparam int DIV_ITERS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_mag;
    typedef logic [RES_W-1:0]          t_res;
    typedef logic [IDX_W-1:0]          t_index;
    typedef logic [REM_W-1:0]          t_rem;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MULX,
        F_MULY,
        F_MULR,
        F_INIT,
        F_SEARCH,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } t_back_state;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord goal_x;
        t_coord goal_y;
        t_mag   mag_x;
        t_mag   mag_y;
        logic   neg_x;
        logic   neg_y;
        t_index steps;
        logic   clamped;
    } t_job;

endpackage

`default_nettype wire

// ----- hdl/lsps_if.sv -----
// Request channels of the line segment point sampler
`default_nettype none

interface lsps_in_if;
    logic                 valid;
    logic                 ready;
    lsps_pkg::t_coord     start_x;
    lsps_pkg::t_coord     start_y;
    lsps_pkg::t_coord     goal_x;
    lsps_pkg::t_coord     goal_y;

    modport source (output valid, start_x, start_y, goal_x, goal_y, input ready);
    modport sink   (input valid, start_x, start_y, goal_x, goal_y, output ready);
endinterface

interface lsps_out_if;
    logic                 valid;
    logic                 ready;
    lsps_pkg::t_coord     point_x;
    lsps_pkg::t_coord     point_y;
    lsps_pkg::t_index     point_index;
    logic                 step_clamped;
    logic                 run_last;

    modport source (output valid, point_x, point_y, point_index, step_clamped, run_last,
                    input ready);
    modport sink   (input valid, point_x, point_y, point_index, step_clamped, run_last,
                    output ready);
endinterface

interface lsps_cfg_if;
    logic                 valid;
    logic                 ready;
    lsps_pkg::t_res       grid_resolution;

    modport source (output valid, grid_resolution, input ready);
    modport sink   (input valid, grid_resolution, output ready);
endinterface

`default_nettype wire

// ----- hdl/line_segment_point_sampler_unit.sv -----
// Top level of the line segment point sampler
//
// Usage: a request on i_seg carries a start and a goal point (signed fixed point).
// Each request yields a run of points on o_pt: the start point (index 0), evenly
// spaced points along the segment, and the goal point flagged run_last. A run
// holds steps + 1 points, steps = ceil(distance / grid_resolution), at least 1
// and at most MAX_STEPS; step_clamped marks every point of a saturated run.
// i_cfg writes grid_resolution; it is always ready. The user is to write it only while
// idle; the block itself does not enforce this. Front end: squares dx, dy and
// grid_resolution, then searches step counts 1 to MAX_STEPS on the squared-length
// compare; the front end then hands the job to a two-entry queue.
// Back end: shift-subtract division, then one point per cycle while o_pt is ready.
// The front end can take the next request while the back end still works on the
// previous one, as long as the queue has room.
// Reset clears all control state; grid_resolution returns to 0.05 m.
// When o_pt stalls the output register holds its point, the back end waits,
// and the queue and front end keep working until the queue fills.
`default_nettype none

module line_segment_point_sampler_unit #(
    parameter int MAX_STEPS       = 63,
    parameter int COORD_FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    lsps_in_if.sink        i_seg,
    lsps_out_if.source     o_pt,
    lsps_cfg_if.sink       i_cfg
);

`include "line_segment_point_sampler_unit_assert.svh"

    localparam lsps_pkg::t_res ResReset =
        lsps_pkg::t_res'(((64'd5 << COORD_FRAC_BITS) + 64'd50) / 64'd100);

    lsps_pkg::t_res r_grid_res;
    lsps_pkg::t_job w_front_job, w_back_job;
    logic           w_front_valid, w_front_ready;
    logic           w_back_valid, w_back_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_res <= ResReset;
        end else if (i_cfg.valid) begin
            r_grid_res <= i_cfg.grid_resolution;
        end
    end

    lsps_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (i_seg),
        .i_grid_res  (r_grid_res),
        .o_job       (w_front_job),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready)
    );

    lsps_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_data  (w_front_job),
        .o_rd_valid (w_back_valid),
        .i_rd_ready (w_back_ready),
        .o_rd_data  (w_back_job)
    );

    lsps_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_back_job),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .o_pt        (o_pt)
    );

    `LSPS_ASSERT_IMP(a_index_range, i_clk, i_rst_n, o_pt.valid,
        o_pt.point_index <= lsps_pkg::t_index'(MAX_STEPS), "point index beyond step limit")
    `LSPS_ASSERT_IMP(a_clamp_len, i_clk, i_rst_n, o_pt.valid && o_pt.run_last && o_pt.step_clamped,
        o_pt.point_index == lsps_pkg::t_index'(MAX_STEPS), "clamped run has wrong length")
    `LSPS_ASSERT_NXT(a_run_restart, i_clk, i_rst_n, o_pt.valid && o_pt.ready && o_pt.run_last,
        !o_pt.valid || (o_pt.point_index == '0), "new run does not start at index zero")
    `LSPS_ASSERT_NXT(a_run_advance, i_clk, i_rst_n, o_pt.valid && o_pt.ready && !o_pt.run_last,
        !o_pt.valid || (o_pt.point_index == $past(o_pt.point_index) + 1'b1), "index skipped")

endmodule

`default_nettype wire

// ----- hdl/lsps_front.sv -----
// Front end: accepts segments and finds the step count by an incremental square search
`default_nettype none

module lsps_front #(
    parameter int MAX_STEPS = 63
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    lsps_in_if.sink              i_seg,
    input  lsps_pkg::t_res       i_grid_res,
    output lsps_pkg::t_job       o_job,
    output logic                 o_job_valid,
    input  wire                  i_job_ready
);

    lsps_pkg::t_front_state r_state, n_state;

    lsps_pkg::t_coord r_sx, r_sy, r_gx, r_gy;
    lsps_pkg::t_mag   r_mag_x, r_mag_y;
    logic             r_neg_x, r_neg_y;
    logic [lsps_pkg::PROD_W-1:0] r_prod;
    logic [lsps_pkg::D2_W-1:0]   r_d2;
    logic [lsps_pkg::PROD_W-1:0] r_r2;
    logic [lsps_pkg::SQ_W-1:0]   r_sq, r_inc;
    lsps_pkg::t_index r_n, r_steps;
    logic             r_clamped;

    logic signed [lsps_pkg::COORD_W:0] w_dx, w_dy;
    logic [lsps_pkg::MUL_W-1:0]        w_mul_a;
    logic [lsps_pkg::PROD_W-1:0]       w_prod;
    logic                              w_hit;
    logic                              w_at_max;

    assign w_dx = (lsps_pkg::COORD_W+1)'(i_seg.goal_x) - (lsps_pkg::COORD_W+1)'(i_seg.start_x);
    assign w_dy = (lsps_pkg::COORD_W+1)'(i_seg.goal_y) - (lsps_pkg::COORD_W+1)'(i_seg.start_y);

    always_comb begin
        case (r_state)
            lsps_pkg::F_MULX: w_mul_a = r_mag_x;
            lsps_pkg::F_MULY: w_mul_a = r_mag_y;
            default:          w_mul_a = lsps_pkg::MUL_W'(i_grid_res);
        endcase
    end

    assign w_prod   = lsps_pkg::PROD_W'(w_mul_a) * lsps_pkg::PROD_W'(w_mul_a);
    assign w_hit    = r_sq >= lsps_pkg::SQ_W'(r_d2);
    assign w_at_max = r_n == lsps_pkg::t_index'(MAX_STEPS);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsps_pkg::F_IDLE: begin
                if (i_seg.valid) begin
                    n_state = lsps_pkg::F_MULX;
                end
            end
            lsps_pkg::F_MULX:   n_state = lsps_pkg::F_MULY;
            lsps_pkg::F_MULY:   n_state = lsps_pkg::F_MULR;
            lsps_pkg::F_MULR:   n_state = lsps_pkg::F_INIT;
            lsps_pkg::F_INIT:   n_state = lsps_pkg::F_SEARCH;
            lsps_pkg::F_SEARCH: begin
                if (w_hit || w_at_max) begin
                    n_state = lsps_pkg::F_PUSH;
                end
            end
            lsps_pkg::F_PUSH: begin
                if (i_job_ready) begin
                    n_state = lsps_pkg::F_IDLE;
                end
            end
            default: n_state = lsps_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        i_seg.ready = r_state == lsps_pkg::F_IDLE;
        o_job_valid = r_state == lsps_pkg::F_PUSH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lsps_pkg::F_IDLE: begin
                r_sx    <= i_seg.start_x;
                r_sy    <= i_seg.start_y;
                r_gx    <= i_seg.goal_x;
                r_gy    <= i_seg.goal_y;
                r_neg_x <= w_dx[lsps_pkg::COORD_W];
                r_neg_y <= w_dy[lsps_pkg::COORD_W];
                r_mag_x <= w_dx[lsps_pkg::COORD_W] ? lsps_pkg::t_mag'(-w_dx)
                                                   : lsps_pkg::t_mag'(w_dx);
                r_mag_y <= w_dy[lsps_pkg::COORD_W] ? lsps_pkg::t_mag'(-w_dy)
                                                   : lsps_pkg::t_mag'(w_dy);
            end
            lsps_pkg::F_MULX: begin
                r_prod <= w_prod;
            end
            lsps_pkg::F_MULY: begin
                r_prod <= w_prod;
                r_d2   <= lsps_pkg::D2_W'(r_prod);
            end
            lsps_pkg::F_MULR: begin
                r_prod <= w_prod;
                r_d2   <= r_d2 + lsps_pkg::D2_W'(r_prod);
            end
            lsps_pkg::F_INIT: begin
                r_r2  <= r_prod;
                r_sq  <= lsps_pkg::SQ_W'(r_prod);
                r_inc <= lsps_pkg::SQ_W'(r_prod) + (lsps_pkg::SQ_W'(r_prod) << 1);
                r_n   <= lsps_pkg::t_index'(1);
            end
            lsps_pkg::F_SEARCH: begin
                if (w_hit) begin
                    r_steps   <= r_n;
                    r_clamped <= 1'b0;
                end else if (w_at_max) begin
                    r_steps   <= lsps_pkg::t_index'(MAX_STEPS);
                    r_clamped <= 1'b1;
                end else begin
                    r_sq  <= r_sq + r_inc;
                    r_inc <= r_inc + (lsps_pkg::SQ_W'(r_r2) << 1);
                    r_n   <= r_n + lsps_pkg::t_index'(1);
                end
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
    end

    always_comb begin
        o_job.start_x = r_sx;
        o_job.start_y = r_sy;
        o_job.goal_x  = r_gx;
        o_job.goal_y  = r_gy;
        o_job.mag_x   = r_mag_x;
        o_job.mag_y   = r_mag_y;
        o_job.neg_x   = r_neg_x;
        o_job.neg_y   = r_neg_y;
        o_job.steps   = r_steps;
        o_job.clamped = r_clamped;
    end

endmodule

`default_nettype wire

// ----- hdl/lsps_fifo.sv -----
// Two-entry job queue between front end and back end
`default_nettype none

module lsps_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr_valid,
    output logic                 o_wr_ready,
    input  lsps_pkg::t_job       i_wr_data,
    output logic                 o_rd_valid,
    input  wire                  i_rd_ready,
    output lsps_pkg::t_job       o_rd_data
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);

    lsps_pkg::t_job     r_mem [Depth];
    logic [PtrW-1:0]    r_wptr, r_rptr;
    logic [PtrW:0]      r_count;
    logic               w_push, w_pop;

    assign o_wr_ready = r_count != (PtrW+1)'(Depth);
    assign o_rd_valid = r_count != '0;
    assign o_rd_data  = r_mem[r_rptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (PtrW+1)'(1);
                2'b01:   r_count <= r_count - (PtrW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lsps_back.sv -----
// Back end: divides the segment into steps and emits the points through an output register
`default_nettype none

module lsps_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lsps_pkg::t_job       i_job,
    input  wire                  i_job_valid,
    output logic                 o_job_ready,
    lsps_out_if.source           o_pt
);

    localparam int StepW = lsps_pkg::REM_W + lsps_pkg::COORD_W;

    lsps_pkg::t_back_state r_state, n_state;

    lsps_pkg::t_job   r_job;
    logic [lsps_pkg::DIV_CNT_W-1:0] r_cnt;
    lsps_pkg::t_mag   r_quo_x, r_quo_y;
    lsps_pkg::t_rem   r_rem_x, r_rem_y;
    lsps_pkg::t_mag   r_acc_x, r_acc_y;
    lsps_pkg::t_rem   r_frac_x, r_frac_y;
    lsps_pkg::t_index r_j;

    logic             r_ov;
    lsps_pkg::t_coord r_px, r_py;
    lsps_pkg::t_index r_pidx;
    logic             r_pcl, r_plast;

    logic [StepW-1:0] w_div_x, w_div_y, w_acc_nx, w_acc_ny;
    lsps_pkg::t_mag   w_off_x, w_off_y;
    logic             w_div_done, w_last, w_load;

    function automatic logic [StepW-1:0] f_div_step(
        input lsps_pkg::t_rem   rem,
        input lsps_pkg::t_mag   quo,
        input lsps_pkg::t_index d
    );
        lsps_pkg::t_rem trial;
        logic           ge;
        trial = {rem[lsps_pkg::REM_W-2:0], quo[lsps_pkg::COORD_W-1]};
        ge    = trial >= lsps_pkg::t_rem'(d);
        return {ge ? trial - lsps_pkg::t_rem'(d) : trial, quo[lsps_pkg::COORD_W-2:0], ge};
    endfunction

    function automatic logic [StepW-1:0] f_acc_step(
        input lsps_pkg::t_mag   acc,
        input lsps_pkg::t_rem   frac,
        input lsps_pkg::t_mag   q,
        input lsps_pkg::t_rem   r,
        input lsps_pkg::t_index d
    );
        lsps_pkg::t_rem sum;
        logic           wrap;
        sum  = frac + r;
        wrap = sum >= lsps_pkg::t_rem'(d);
        return {wrap ? sum - lsps_pkg::t_rem'(d) : sum,
                acc + q + lsps_pkg::t_mag'(wrap)};
    endfunction

    assign w_div_x  = f_div_step(r_rem_x, r_quo_x, r_job.steps);
    assign w_div_y  = f_div_step(r_rem_y, r_quo_y, r_job.steps);
    assign w_acc_nx = f_acc_step(r_acc_x, r_frac_x, r_quo_x, r_rem_x, r_job.steps);
    assign w_acc_ny = f_acc_step(r_acc_y, r_frac_y, r_quo_y, r_rem_y, r_job.steps);
    assign w_off_x  = r_job.neg_x ? (~r_acc_x + lsps_pkg::t_mag'(1)) : r_acc_x;
    assign w_off_y  = r_job.neg_y ? (~r_acc_y + lsps_pkg::t_mag'(1)) : r_acc_y;

    assign w_div_done = r_cnt == lsps_pkg::DIV_CNT_W'(lsps_pkg::DIV_ITERS - 1);
    assign w_last     = r_j == r_job.steps;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsps_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = lsps_pkg::B_DIV;
                end
            end
            lsps_pkg::B_DIV: begin
                if (w_div_done) begin
                    n_state = lsps_pkg::B_EMIT;
                end
            end
            lsps_pkg::B_EMIT: begin
                if (w_load && w_last) begin
                    n_state = lsps_pkg::B_IDLE;
                end
            end
            default: n_state = lsps_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_job_ready = r_state == lsps_pkg::B_IDLE;
        w_load      = (r_state == lsps_pkg::B_EMIT) && (!r_ov || o_pt.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsps_pkg::B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (o_pt.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lsps_pkg::B_IDLE: begin
                r_job   <= i_job;
                r_quo_x <= i_job.mag_x;
                r_quo_y <= i_job.mag_y;
                r_rem_x <= '0;
                r_rem_y <= '0;
                r_cnt   <= '0;
            end
            lsps_pkg::B_DIV: begin
                {r_rem_x, r_quo_x} <= w_div_x;
                {r_rem_y, r_quo_y} <= w_div_y;
                r_cnt    <= r_cnt + lsps_pkg::DIV_CNT_W'(1);
                r_acc_x  <= '0;
                r_acc_y  <= '0;
                r_frac_x <= '0;
                r_frac_y <= '0;
                r_j      <= '0;
            end
            default: begin
                if (w_load) begin
                    {r_frac_x, r_acc_x} <= w_acc_nx;
                    {r_frac_y, r_acc_y} <= w_acc_ny;
                    r_j <= r_j + lsps_pkg::t_index'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px    <= w_last ? r_job.goal_x : lsps_pkg::t_coord'(r_job.start_x + w_off_x);
            r_py    <= w_last ? r_job.goal_y : lsps_pkg::t_coord'(r_job.start_y + w_off_y);
            r_pidx  <= r_j;
            r_pcl   <= r_job.clamped;
            r_plast <= w_last;
        end
    end

    assign o_pt.valid        = r_ov;
    assign o_pt.point_x      = r_px;
    assign o_pt.point_y      = r_py;
    assign o_pt.point_index  = r_pidx;
    assign o_pt.step_clamped = r_pcl;
    assign o_pt.run_last     = r_plast;

endmodule

`default_nettype wire

// ----- tb/sv/tb_line_segment_point_sampler_unit.sv -----
// Testbench for the line segment point sampler: directed and random segments checked per point
module tb_line_segment_point_sampler_unit;

    localparam int               SEG_MAX_STEPS = 63;
    localparam int               FRAC_BITS     = 16;
    localparam lsps_pkg::t_res   RES_AT_RESET  =
        lsps_pkg::t_res'(((5 << FRAC_BITS) + 50) / 100);
    localparam lsps_pkg::t_res   RES_TOP       = 31'h7fff_ffff;
    localparam lsps_pkg::t_coord C_MAX         = 32'sh7fff_ffff;
    localparam lsps_pkg::t_coord C_MIN         = 32'sh8000_0000;
    localparam longint           COORD_HI      = 64'sd2147483647;
    localparam longint           COORD_LO      = -64'sd2147483648;
    localparam int               PHASE_ITEMS   = 68;

    typedef struct packed {
        lsps_pkg::t_coord sx;
        lsps_pkg::t_coord sy;
        lsps_pkg::t_coord gx;
        lsps_pkg::t_coord gy;
    } t_segment;

    typedef struct packed {
        lsps_pkg::t_coord x;
        lsps_pkg::t_coord y;
        lsps_pkg::t_index idx;
        logic             clamped;
        logic             is_last;
    } t_point;

    logic           i_clk;
    logic           i_rst_n;
    logic           calm;
    lsps_pkg::t_res grid_res;
    int             mismatches = 0;
    int             ready_hold = 0;
    t_point         want_point;
    t_point         seen_point;
    t_point         expected_points[$];

    lsps_in_if  seg_if();
    lsps_out_if pt_if();
    lsps_cfg_if cfg_if();

    line_segment_point_sampler_unit #(
        .MAX_STEPS      (SEG_MAX_STEPS),
        .COORD_FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if.sink),
        .o_pt   (pt_if.source),
        .i_cfg  (cfg_if.sink)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 1;
        if (roll < 85) return $urandom_range(2, 4);
        if (roll < 97) return $urandom_range(5, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_segment make_seg(lsps_pkg::t_coord sx, lsps_pkg::t_coord sy,
                                          lsps_pkg::t_coord gx, lsps_pkg::t_coord gy);
        t_segment s;
        s.sx = sx;
        s.sy = sy;
        s.gx = gx;
        s.gy = gy;
        return s;
    endfunction

    function automatic void predict_run(t_segment s);
        longint       dx;
        longint       dy;
        longint       px;
        longint       py;
        logic [127:0] mag_x;
        logic [127:0] mag_y;
        logic [127:0] len2;
        logic [127:0] reach;
        int           steps;
        int           n;
        int           j;
        logic         sat;
        t_point       p;
        dx = longint'(s.gx) - longint'(s.sx);
        dy = longint'(s.gy) - longint'(s.sy);
        mag_x = (dx < 0) ? 128'(-dx) : 128'(dx);
        mag_y = (dy < 0) ? 128'(-dy) : 128'(dy);
        len2 = mag_x * mag_x + mag_y * mag_y;
        steps = 1;
        sat = 1'b0;
        if (128'(grid_res) * 128'(grid_res) < len2) begin
            steps = SEG_MAX_STEPS;
            sat = 1'b1;
            n = 2;
            while (sat && n <= SEG_MAX_STEPS) begin
                reach = 128'(n) * 128'(grid_res);
                if (reach * reach >= len2) begin
                    steps = n;
                    sat = 1'b0;
                end
                n++;
            end
        end
        p.x = s.sx;
        p.y = s.sy;
        p.idx = '0;
        p.clamped = sat;
        p.is_last = 1'b0;
        expected_points.insert(expected_points.size(), p);
        for (j = 1; j < steps; j++) begin
            px = longint'(s.sx) + (longint'(j) * dx) / longint'(steps);
            py = longint'(s.sy) + (longint'(j) * dy) / longint'(steps);
            p.x = px[lsps_pkg::COORD_W-1:0];
            p.y = py[lsps_pkg::COORD_W-1:0];
            p.idx = j[lsps_pkg::IDX_W-1:0];
            expected_points.insert(expected_points.size(), p);
        end
        p.x = s.gx;
        p.y = s.gy;
        p.idx = steps[lsps_pkg::IDX_W-1:0];
        p.is_last = 1'b1;
        expected_points.insert(expected_points.size(), p);
    endfunction

    function automatic lsps_pkg::t_coord offset_coord(lsps_pkg::t_coord base, longint span_len);
        longint t;
        bit     neg;
        neg = ($urandom_range(0, 1) != 0);
        t = neg ? longint'(base) - span_len : longint'(base) + span_len;
        if (t > COORD_HI || t < COORD_LO)
            t = neg ? longint'(base) + span_len : longint'(base) - span_len;
        if (t > COORD_HI) t = COORD_HI;
        else if (t < COORD_LO) t = COORD_LO;
        return t[lsps_pkg::COORD_W-1:0];
    endfunction

    function automatic t_segment random_segment();
        t_segment        s;
        int unsigned     kind;
        int unsigned     n;
        longint unsigned span;
        longint          ax;
        longint          ay;
        s.sx = $urandom;
        s.sy = $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            s.gx = $urandom;
            s.gy = $urandom;
        end else if (kind < 15) begin
            s.gx = s.sx;
            s.gy = s.sy;
        end else begin
            if (kind < 65) begin
                n = $urandom_range(1, 70);
                span = longint'(grid_res) * n;
                if (span > 64'h7fff_ffff) span = 64'h7fff_ffff;
                ax = longint'($urandom_range(0, span[31:0]));
                ay = longint'($urandom_range(0, span[31:0]));
            end else begin
                ax = longint'($urandom) & ((64'd1 << $urandom_range(0, 32)) - 1);
                ay = longint'($urandom) & ((64'd1 << $urandom_range(0, 32)) - 1);
            end
            s.gx = offset_coord(s.sx, ax);
            s.gy = offset_coord(s.sy, ay);
        end
        return s;
    endfunction

    task automatic send_segment(t_segment s);
        int unsigned gap;
        seg_if.valid   <= 1'b1;
        seg_if.start_x <= s.sx;
        seg_if.start_y <= s.sy;
        seg_if.goal_x  <= s.gx;
        seg_if.goal_y  <= s.gy;
        @(posedge i_clk);
        while (seg_if.ready !== 1'b1) @(posedge i_clk);
        predict_run(s);
        gap = (calm || $urandom_range(0, 1)) ? 0 : draw_gap();
        if (gap != 0) begin
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        seg_if.valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_resolution(lsps_pkg::t_res value);
        cfg_if.valid           <= 1'b1;
        cfg_if.grid_resolution <= value;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        grid_res = value;
    endtask

    task automatic test_short_and_equal_points();
        int r;
        r = int'(grid_res);
        send_segment(make_seg(0, 0, 0, 0));
        send_segment(make_seg(C_MAX, C_MIN, C_MAX, C_MIN));
        send_segment(make_seg(100, 200, 100 + r, 200));
        send_segment(make_seg(5, 5, 5 + 2000, 5 + 2000));
        send_segment(make_seg(-7, 9, -7, 9 - r));
    endtask

    task automatic test_step_boundaries();
        int r;
        r = int'(grid_res);
        send_segment(make_seg(0, 0, 0, -(r + 1)));
        send_segment(make_seg(0, 0, -(3 * r + 2), 7));
        send_segment(make_seg(1000, -1000, 1000 + 10 * r, -1000));
        send_segment(make_seg(1000, -1000, 1000 + 10 * r + 1, -1000));
        send_segment(make_seg(0, 0, 63 * r, 0));
        send_segment(make_seg(0, 0, -63 * r, -1));
        send_segment(make_seg(0, 0, 0, 63 * r + 1));
    endtask

    task automatic test_coordinate_extremes();
        send_segment(make_seg(C_MIN, C_MIN, C_MAX, C_MAX));
        send_segment(make_seg(C_MAX, C_MAX, C_MIN, C_MIN));
        send_segment(make_seg(C_MIN, C_MAX, C_MAX, C_MIN));
        send_segment(make_seg(C_MAX, 0, C_MIN, 0));
    endtask

    task automatic test_resolution_extremes();
        wait_idle();
        set_resolution(31'd1);
        send_segment(make_seg(3, 3, 3, 3));
        send_segment(make_seg(0, 0, -63, 0));
        send_segment(make_seg(0, 0, 64, 0));
        send_segment(make_seg(0, 0, 3, -4));
        wait_idle();
        set_resolution(RES_TOP);
        send_segment(make_seg(C_MIN, C_MIN, C_MAX, C_MAX));
        send_segment(make_seg(C_MIN, 0, C_MAX, 0));
        send_segment(make_seg(0, 0, C_MAX, 0));
    endtask

    task automatic test_zero_resolution();
        wait_idle();
        set_resolution('0);
        send_segment(make_seg(1, 2, 1, 2));
        send_segment(make_seg(0, 0, 0, -1));
    endtask

    task automatic test_random_sweep();
        lsps_pkg::t_res plan[6];
        int             k;
        plan[0] = RES_AT_RESET;
        plan[1] = 31'd65536;
        plan[2] = lsps_pkg::t_res'($urandom_range(2, 5000));
        plan[3] = 31'd1;
        plan[4] = RES_TOP;
        plan[5] = lsps_pkg::t_res'($urandom_range(1, 32'h7fff_ffff));
        for (k = 0; k < 6; k++) begin
            wait_idle();
            set_resolution(plan[k]);
            repeat (PHASE_ITEMS) send_segment(random_segment());
        end
        wait_idle();
    endtask

    initial begin
        calm <= 1'b0;
        forever begin
            repeat ($urandom_range(50, 400)) @(posedge i_clk);
            calm <= ($urandom_range(0, 3) == 0);
        end
    end

    initial begin
        pt_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                pt_if.ready <= 1'b0;
                ready_hold--;
            end else begin
                pt_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) ready_hold = draw_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (pt_if.valid === 1'b1 && pt_if.ready === 1'b1) begin
            seen_point.x       = pt_if.point_x;
            seen_point.y       = pt_if.point_y;
            seen_point.idx     = pt_if.point_index;
            seen_point.clamped = pt_if.step_clamped;
            seen_point.is_last = pt_if.run_last;
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected point: x=%0d y=%0d index=%0d clamped=%0b last=%0b",
                             seen_point.x, seen_point.y, seen_point.idx,
                             seen_point.clamped, seen_point.is_last);
            end else begin
                want_point = expected_points.pop_front();
                if (want_point.x !== seen_point.x || want_point.y !== seen_point.y ||
                    want_point.idx !== seen_point.idx ||
                    want_point.clamped !== seen_point.clamped ||
                    want_point.is_last !== seen_point.is_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"point mismatch: expected x=%0d y=%0d index=%0d ",
                                  "clamped=%0b last=%0b, got x=%0d y=%0d index=%0d ",
                                  "clamped=%0b last=%0b"},
                                 want_point.x, want_point.y, want_point.idx,
                                 want_point.clamped, want_point.is_last,
                                 seen_point.x, seen_point.y, seen_point.idx,
                                 seen_point.clamped, seen_point.is_last);
                end
            end
        end
    end

    initial begin
        #12_000_000;
        $display("tb_line_segment_point_sampler_unit: FAIL");
        $finish;
    end

    initial begin
        i_rst_n                <= 1'b0;
        seg_if.valid           <= 1'b0;
        seg_if.start_x         <= '0;
        seg_if.start_y         <= '0;
        seg_if.goal_x          <= '0;
        seg_if.goal_y          <= '0;
        cfg_if.valid           <= 1'b0;
        cfg_if.grid_resolution <= '0;
        grid_res = RES_AT_RESET;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_short_and_equal_points();
        test_step_boundaries();
        test_coordinate_extremes();
        test_resolution_extremes();
        test_zero_resolution();
        test_random_sweep();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_line_segment_point_sampler_unit: PASS");
        end else begin
            $display("tb_line_segment_point_sampler_unit: FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/lsps_pkg.sv
hdl/lsps_if.sv
hdl/lsps_front.sv
hdl/lsps_fifo.sv
hdl/lsps_back.sv
hdl/line_segment_point_sampler_unit.sv
tb/sv/tb_line_segment_point_sampler_unit.sv
